// File: src/lru_pkg.sv
// ----------------------------------------------------------------------------
// lru_pkg
// Shared types and codes for the LRU replacement list: request and response
// payloads, request kinds and the link update bundle between the list
// controller and the link table.
// ----------------------------------------------------------------------------
package lru_pkg;

    localparam int KEY_W  = 6;
    localparam int KIND_W = 2;
    localparam int CNT_W  = 7;

    typedef logic [KEY_W-1:0] key_t;
    typedef logic [CNT_W-1:0] cnt_t;

    // Request kinds; the remaining code is a no-op.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_VICTIM = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ERASE  = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        key_t              key;
    } req_t;

    typedef struct packed {
        logic ok;
        key_t victim_key;
        cnt_t count;
    } resp_t;

    // One write into a link table entry.
    typedef struct packed {
        logic en;
        key_t addr;
        key_t data;
    } link_wr_t;

    // All link writes a single request can cause. The two writes into the
    // same table always target different entries.
    typedef struct packed {
        link_wr_t newer_unlink;
        link_wr_t newer_append;
        link_wr_t older_unlink;
        link_wr_t older_append;
    } link_upd_t;

endpackage

// File: src/lru_replacer_core.sv
// ----------------------------------------------------------------------------
// lru_replacer_core
// LRU replacement list over frame keys: insert or touch, take victim and
// erase requests, one response per request.
//
//   channel | direction | payload | handshake
//   --------+-----------+---------+----------------------------
//   req     | in        | req_t   | req_valid / req_stall
//   resp    | out       | resp_t  | resp_valid / resp_stall
//
// A request is registered on transfer together with the links of its key,
// read with the writes of the retiring request passed through. It retires,
// with the list state and the response register updating together, when
// the response slot is free. One request per cycle is sustained unless resp
// stalls, set by the pass from the registered links through decode to writes.
// Reset clears presence, list ends and count; link memories are not reset.
// A stalled response holds the request register, which then stalls req.
// ----------------------------------------------------------------------------
module lru_replacer_core #(
    parameter int NUM_KEYS = 64
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  lru_pkg::req_t  req,
    output logic           resp_valid,
    input  logic           resp_stall,
    output lru_pkg::resp_t resp
);
    import lru_pkg::*;

    // Keys are six bits wide, so at most 64 cells are ever used.
    localparam int DEPTH = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);

    req_t  item_reg;
    logic  item_valid_reg;
    resp_t resp_reg;
    logic  resp_valid_reg;

    logic      advance;
    logic      go;
    logic      accept;
    key_t      rd_addr;
    key_t      rd_newer;
    key_t      rd_older;
    link_upd_t upd;
    resp_t     result;

    // Handshake: the request stage moves whenever the response slot frees.
    assign advance   = !resp_valid_reg || !resp_stall;
    assign go        = item_valid_reg && advance;
    assign req_stall = item_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;

    // Request register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            item_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            item_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

    // Response register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            resp_valid_reg <= 1'b0;
        end
        else
        begin
            resp_valid_reg <= go || (resp_valid_reg && resp_stall);
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            resp_reg <= result;
        end
    end

    assign resp_valid = resp_valid_reg;
    assign resp       = resp_reg;

    lru_list_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (go),
        .item     (item_reg),
        .incoming (req),
        .rd_newer (rd_newer),
        .rd_older (rd_older),
        .rd_addr  (rd_addr),
        .upd      (upd),
        .result   (result)
    );

    lru_link_table #(
        .DEPTH (DEPTH)
    ) u_links (
        .clk      (clk),
        .upd      (upd),
        .rd_en    (accept),
        .rd_addr  (rd_addr),
        .rd_newer (rd_newer),
        .rd_older (rd_older)
    );

endmodule

// File: src/lru_link_table.sv
// ----------------------------------------------------------------------------
// lru_link_table
// Newer and older link memories for every key. The links of the key under
// work are read into registers when its request transfers, with the writes
// of the request retiring in the same cycle passed through to the read data.
// ----------------------------------------------------------------------------
module lru_link_table #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  lru_pkg::link_upd_t upd,
    input  logic               rd_en,
    input  lru_pkg::key_t      rd_addr,
    output lru_pkg::key_t      rd_newer,
    output lru_pkg::key_t      rd_older
);
    import lru_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    key_t newer_reg [DEPTH];
    key_t older_reg [DEPTH];
    key_t rd_newer_reg;
    key_t rd_older_reg;

    // Link writes of the retiring request; the two writes into one memory
    // never share an entry.
    always_ff @(posedge clk)
    begin
        if (upd.newer_unlink.en)
        begin
            newer_reg[upd.newer_unlink.addr[IDX_W-1:0]] <= upd.newer_unlink.data;
        end
        if (upd.newer_append.en)
        begin
            newer_reg[upd.newer_append.addr[IDX_W-1:0]] <= upd.newer_append.data;
        end
        if (upd.older_unlink.en)
        begin
            older_reg[upd.older_unlink.addr[IDX_W-1:0]] <= upd.older_unlink.data;
        end
        if (upd.older_append.en)
        begin
            older_reg[upd.older_append.addr[IDX_W-1:0]] <= upd.older_append.data;
        end
    end

    // Registered read for the incoming request. A link written in the same
    // cycle is taken from the write bundle instead of the memory.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            priority if (upd.newer_append.en && upd.newer_append.addr == rd_addr)
            begin
                rd_newer_reg <= upd.newer_append.data;
            end
            else if (upd.newer_unlink.en && upd.newer_unlink.addr == rd_addr)
            begin
                rd_newer_reg <= upd.newer_unlink.data;
            end
            else
            begin
                rd_newer_reg <= newer_reg[rd_addr[IDX_W-1:0]];
            end

            priority if (upd.older_append.en && upd.older_append.addr == rd_addr)
            begin
                rd_older_reg <= upd.older_append.data;
            end
            else if (upd.older_unlink.en && upd.older_unlink.addr == rd_addr)
            begin
                rd_older_reg <= upd.older_unlink.data;
            end
            else
            begin
                rd_older_reg <= older_reg[rd_addr[IDX_W-1:0]];
            end
        end
    end

    assign rd_newer = rd_newer_reg;
    assign rd_older = rd_older_reg;

endmodule

// File: src/lru_list_ctrl.sv
// ----------------------------------------------------------------------------
// lru_list_ctrl
// Presence bits, list ends and key count. Decodes one request per cycle
// while go is high, issues the link writes for unlink and append, forms
// the response and picks the link address for the incoming request.
// ----------------------------------------------------------------------------
module lru_list_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               go,
    input  lru_pkg::req_t      item,
    input  lru_pkg::req_t      incoming,
    input  lru_pkg::key_t      rd_newer,
    input  lru_pkg::key_t      rd_older,
    output lru_pkg::key_t      rd_addr,
    output lru_pkg::link_upd_t upd,
    output lru_pkg::resp_t     result
);
    import lru_pkg::*;

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [DEPTH-1:0] present_reg, present_next;
    key_t             oldest_reg, oldest_next;
    key_t             newest_reg, newest_next;
    cnt_t             tracked_reg, tracked_next;

    logic in_space;
    logic key_present;
    logic is_oldest;
    logic is_newest;
    logic last_key;
    key_t k;
    key_t head_key;

    assign k           = item.key;
    assign in_space    = 32'(k) < DEPTH;
    assign key_present = in_space && present_reg[k[IDX_W-1:0]];
    assign is_oldest   = (k == oldest_reg);
    assign is_newest   = (k == newest_reg);
    assign last_key    = (tracked_reg == CNT_W'(1));

    // The incoming request is read against the list as it stands after the
    // request retiring this cycle. A victim walks from the oldest key; other
    // requests look at their own key.
    assign head_key = go ? oldest_next : oldest_reg;
    assign rd_addr  = (incoming.kind == KIND_VICTIM) ? head_key : incoming.key;

    // Request decode: list ends, presence, count and link writes.
    always_comb
    begin
        present_next = present_reg;
        oldest_next  = oldest_reg;
        newest_next  = newest_reg;
        tracked_next = tracked_reg;
        upd          = '0;
        result       = '0;

        unique case (item.kind)
            KIND_INSERT:
            begin
                if (key_present)
                begin
                    result.ok = 1'b1;
                    if (!is_newest)
                    begin
                        // Unlink from the middle or the oldest end.
                        if (is_oldest)
                        begin
                            oldest_next = rd_newer;
                        end
                        else
                        begin
                            upd.newer_unlink = '{en: 1'b1, addr: rd_older, data: rd_newer};
                        end
                        upd.older_unlink = '{en: 1'b1, addr: rd_newer, data: rd_older};
                        // Append at the newest end.
                        upd.newer_append = '{en: 1'b1, addr: newest_reg, data: k};
                        upd.older_append = '{en: 1'b1, addr: k, data: newest_reg};
                        newest_next      = k;
                    end
                end
                else if (in_space)
                begin
                    if (tracked_reg != '0)
                    begin
                        upd.newer_append = '{en: 1'b1, addr: newest_reg, data: k};
                        upd.older_append = '{en: 1'b1, addr: k, data: newest_reg};
                    end
                    else
                    begin
                        oldest_next = k;
                    end
                    newest_next                = k;
                    present_next[k[IDX_W-1:0]] = 1'b1;
                    tracked_next               = tracked_reg + CNT_W'(1);
                end
            end

            KIND_VICTIM:
            begin
                if (tracked_reg != '0)
                begin
                    result.ok                           = 1'b1;
                    result.victim_key                   = oldest_reg;
                    present_next[oldest_reg[IDX_W-1:0]] = 1'b0;
                    tracked_next                        = tracked_reg - CNT_W'(1);
                    if (last_key)
                    begin
                        oldest_next = '0;
                        newest_next = '0;
                    end
                    else
                    begin
                        oldest_next = rd_newer;
                    end
                end
            end

            KIND_ERASE:
            begin
                if (key_present)
                begin
                    result.ok = 1'b1;
                    if (is_oldest)
                    begin
                        oldest_next = rd_newer;
                    end
                    else
                    begin
                        upd.newer_unlink = '{en: 1'b1, addr: rd_older, data: rd_newer};
                    end
                    if (is_newest)
                    begin
                        newest_next = rd_older;
                    end
                    else
                    begin
                        upd.older_unlink = '{en: 1'b1, addr: rd_newer, data: rd_older};
                    end
                    present_next[k[IDX_W-1:0]] = 1'b0;
                    tracked_next               = tracked_reg - CNT_W'(1);
                    if (last_key)
                    begin
                        oldest_next = '0;
                        newest_next = '0;
                    end
                end
            end

            default:
            begin
                // No-op request kind.
            end
        endcase

        result.count = tracked_next;

        // Nothing moves unless a request is being retired this cycle.
        if (!go)
        begin
            upd = '0;
        end
    end

    // List state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '0;
            oldest_reg  <= '0;
            newest_reg  <= '0;
            tracked_reg <= '0;
        end
        else if (go)
        begin
            present_reg <= present_next;
            oldest_reg  <= oldest_next;
            newest_reg  <= newest_next;
            tracked_reg <= tracked_next;
        end
    end

endmodule
